FILE: hw/rtl/utca_pkg.sv
package utca_pkg;

  typedef struct packed {
    logic [6:0] year_in;
    logic [3:0] month_in;
    logic [4:0] day_in;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
  } utc_stamp_t;

  typedef struct packed {
    logic [6:0] year_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
  } adj_stamp_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } date_t;

  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  function automatic logic month_ok(input logic [3:0] m);
    return (m >= MONTH_JAN) && (m <= MONTH_DEC);
  endfunction

  // fixed lengths, no leap years
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      MONTH_FEB: len = 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic date_t day_up(input date_t d);
    date_t r;
    logic [5:0] nd;
    r = d;
    nd = {1'b0, d.day} + 6'd1;
    if (month_ok(d.month) && (nd == ({1'b0, month_len(d.month)} + 6'd1))) begin
      r.day = 5'd1;
      if (d.month == MONTH_DEC) begin
        r.month = MONTH_JAN;
        r.year = (d.year >= YEAR_MAX) ? 7'd0 : d.year + 7'd1;
      end else begin
        r.month = d.month + 4'd1;
      end
    end else begin
      r.day = nd[4:0];
    end
    return r;
  endfunction

  function automatic date_t day_down(input date_t d);
    date_t r;
    r = d;
    if (d.day == 5'd0) begin
      r.day = DAY_LAST;
    end else if (d.day == 5'd1 && month_ok(d.month)) begin
      if (d.month == MONTH_JAN) begin
        r.month = MONTH_DEC;
        r.day = DAY_LAST;
        r.year = (d.year == 7'd0 || d.year > YEAR_MAX) ? YEAR_MAX : d.year - 7'd1;
      end else begin
        r.month = d.month - 4'd1;
        r.day = month_len(d.month - 4'd1);
      end
    end else begin
      r.day = d.day - 5'd1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/utc_offset_calendar_adjust_unit.sv
// Channel  Ports                          Handshake
// input    start, busy, utc               item taken when start & !busy
// result   done, adj                      one-cycle strobe, no backpressure
// config   cfg_valid, cfg_ready, cfg_data write when cfg_valid & cfg_ready
//
// Four register stages: half hour, whole hours, first day step, second day step.
// One item per cycle outside reset; an item's valid bit passes v1, v2, v3, then done.
// Sync reset clears valid bits and the offset (zero offset, pass-through).
// busy is high and cfg_ready low only during reset; the receiver cannot stall.
module utc_offset_calendar_adjust_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  utca_pkg::utc_stamp_t utc,
  output logic                done,
  output utca_pkg::adj_stamp_t adj,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  // decoded offset
  logic       fwd;
  logic       bwd;
  logic       half;
  logic [3:0] whole;

  logic [7:0]  cfg_mag;
  logic [15:0] cfg_prod;
  logic [3:0]  cfg_whole;
  logic        cfg_half;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_comb begin
    cfg_mag   = cfg_data[7] ? (~cfg_data + 8'd1) : cfg_data;
    cfg_prod  = {8'd0, cfg_mag} * 16'd205;   // /10 by reciprocal, exact below 1029
    cfg_whole = cfg_prod[14:11];
    cfg_half  = (cfg_mag != ({4'd0, cfg_whole} * 8'd10));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd   <= 1'b0;
      bwd   <= 1'b0;
      half  <= 1'b0;
      whole <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      fwd   <= ~cfg_data[7] && (cfg_data != 8'd0);
      bwd   <= cfg_data[7];
      half  <= cfg_half;
      whole <= cfg_whole;
    end
  end

  // stage 1: half hour
  logic             v1, v1_next;
  utca_pkg::date_t  date1, date1_next;
  logic [5:0]       hour1, hour1_next;
  logic [5:0]       minute1, minute1_next;
  logic             step_a, step_a_next;

  logic [6:0] msum;
  logic [5:0] hinc;

  always_comb begin
    v1_next      = start && !busy;
    date1_next   = '{year: utc.year_in, month: utc.month_in, day: utc.day_in};
    hour1_next   = {1'b0, utc.hour_in};
    minute1_next = utc.minute_in;
    step_a_next  = 1'b0;
    msum         = {1'b0, utc.minute_in} + 7'd30;
    hinc         = {1'b0, utc.hour_in} + 6'd1;
    if (fwd && half) begin
      if (msum > 7'd59) begin
        minute1_next = 6'(msum - 7'd60);
        if (hinc == 6'd24) begin
          hour1_next  = 6'd0;
          step_a_next = 1'b1;
        end else begin
          hour1_next = hinc;
        end
      end else begin
        minute1_next = msum[5:0];
      end
    end else if (bwd && half) begin
      if (utc.minute_in < 6'd30) begin
        minute1_next = utc.minute_in + 6'd30;
        if (utc.hour_in == 5'd0) begin
          hour1_next  = 6'd23;
          step_a_next = 1'b1;
        end else begin
          hour1_next = {1'b0, utc.hour_in - 5'd1};
        end
      end else begin
        minute1_next = utc.minute_in - 6'd30;
      end
    end
  end

  // stage 2: whole hours
  logic             v2;
  utca_pkg::date_t  date2;
  logic [4:0]       hour2, hour2_next;
  logic [5:0]       minute2;
  logic             step_a2;
  logic             step_b, step_b_next;

  logic [5:0] hsum;

  always_comb begin
    hsum        = hour1 + {2'd0, whole};
    hour2_next  = hour1[4:0];
    step_b_next = 1'b0;
    if (fwd) begin
      if (hsum > 6'd23) begin
        hour2_next  = 5'(hsum - 6'd24);
        step_b_next = 1'b1;
      end else begin
        hour2_next = hsum[4:0];
      end
    end else if (bwd) begin
      if (hour1[4:0] < {1'b0, whole}) begin
        hour2_next  = hour1[4:0] + 5'd24 - {1'b0, whole};
        step_b_next = 1'b1;
      end else begin
        hour2_next = hour1[4:0] - {1'b0, whole};
      end
    end
  end

  // stages 3 and 4: day steps, same direction
  logic             v3;
  utca_pkg::date_t  date3, date3_next;
  logic [4:0]       hour3;
  logic [5:0]       minute3;
  logic             step_b3;
  utca_pkg::date_t  date4_next;

  always_comb begin
    date3_next = date2;
    if (step_a2 || step_b) begin
      date3_next = fwd ? utca_pkg::day_up(date2) : utca_pkg::day_down(date2);
    end
    date4_next = date3;
    if (step_b3) begin
      date4_next = fwd ? utca_pkg::day_up(date3) : utca_pkg::day_down(date3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= v1_next;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    date1   <= date1_next;
    hour1   <= hour1_next;
    minute1 <= minute1_next;
    step_a  <= step_a_next;

    date2   <= date1;
    hour2   <= hour2_next;
    minute2 <= minute1;
    step_a2 <= step_a;
    step_b  <= step_b_next;

    date3   <= date3_next;
    hour3   <= hour2;
    minute3 <= minute2;
    step_b3 <= step_a2 && step_b;

    adj.year_out   <= date4_next.year;
    adj.month_out  <= date4_next.month;
    adj.day_out    <= date4_next.day;
    adj.hour_out   <= hour3;
    adj.minute_out <= minute3;
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    int yr;
    int mo;
    int dy;
    int hr;
    int mn;
  } cal_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  utca_pkg::utc_stamp_t utc;
  logic done;
  utca_pkg::adj_stamp_t adj;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_data;

  logic [7:0] offset_reg;
  utca_pkg::adj_stamp_t local_time_q[$];
  utca_pkg::adj_stamp_t want;
  int stamps_sent;
  int stamps_checked;
  int offsets_applied;
  int error_count;
  int mismatch_count;
  int burst_left;
  int stall_cycles;

  utc_offset_calendar_adjust_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .utc(utc),
    .done(done),
    .adj(adj),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int month_days(input int m);
    int len;
    case (m)
      utca_pkg::MONTH_FEB: len = 28;
      utca_pkg::MONTH_APR, utca_pkg::MONTH_JUN, utca_pkg::MONTH_SEP,
      utca_pkg::MONTH_NOV: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic cal_t advance_day(input cal_t c);
    int nd;
    nd = c.dy + 1;
    if (c.mo >= utca_pkg::MONTH_JAN && c.mo <= utca_pkg::MONTH_DEC &&
        nd == month_days(c.mo) + 1) begin
      c.dy = 1;
      if (c.mo == utca_pkg::MONTH_DEC) begin
        c.mo = utca_pkg::MONTH_JAN;
        c.yr = (c.yr >= utca_pkg::YEAR_MAX) ? 0 : c.yr + 1;
      end else begin
        c.mo = c.mo + 1;
      end
    end else begin
      c.dy = nd & 31;
    end
    return c;
  endfunction

  function automatic cal_t retreat_day(input cal_t c);
    int nd;
    nd = c.dy - 1;
    if (nd < 0) begin
      c.dy = 31;
    end else begin
      c.dy = nd;
      if (nd == 0 && c.mo >= utca_pkg::MONTH_JAN && c.mo <= utca_pkg::MONTH_DEC) begin
        if (c.mo == utca_pkg::MONTH_JAN) begin
          c.mo = utca_pkg::MONTH_DEC;
          c.dy = 31;
          c.yr = (c.yr == 0 || c.yr > utca_pkg::YEAR_MAX) ? utca_pkg::YEAR_MAX : c.yr - 1;
        end else begin
          c.mo = c.mo - 1;
          c.dy = month_days(c.mo);
        end
      end
    end
    return c;
  endfunction

  function automatic utca_pkg::adj_stamp_t predict_local_time(input utca_pkg::utc_stamp_t s,
                                                              input logic [7:0] off_bits);
    cal_t c;
    int off;
    int mag;
    int whole;
    bit half;
    utca_pkg::adj_stamp_t r;
    c.yr = s.year_in;
    c.mo = s.month_in;
    c.dy = s.day_in;
    c.hr = s.hour_in;
    c.mn = s.minute_in;
    off = int'($signed(off_bits));
    mag = (off < 0) ? -off : off;
    whole = mag / 10;
    half = (mag % 10) != 0;
    if (off > 0) begin
      if (half) begin
        c.mn = c.mn + 30;
        if (c.mn > 59) begin
          c.mn = c.mn - 60;
          c.hr = c.hr + 1;
          if (c.hr == 24) begin
            c.hr = 0;
            c = advance_day(c);
          end
        end
      end
      c.hr = c.hr + whole;
      if (c.hr > 23) begin
        c.hr = c.hr - 24;
        c = advance_day(c);
      end
    end else if (off < 0) begin
      if (half) begin
        c.mn = c.mn - 30;
        if (c.mn < 0) begin
          c.mn = c.mn + 60;
          c.hr = c.hr - 1;
          if (c.hr < 0) begin
            c.hr = 23;
            c = retreat_day(c);
          end
        end
      end
      c.hr = c.hr - whole;
      if (c.hr < 0) begin
        c.hr = c.hr + 24;
        c = retreat_day(c);
      end
    end
    r.year_out = 7'(c.yr);
    r.month_out = 4'(c.mo);
    r.day_out = 5'(c.dy);
    r.hour_out = 5'(c.hr);
    r.minute_out = 6'(c.mn);
    return r;
  endfunction

  function automatic utca_pkg::utc_stamp_t mk_stamp(input int y, input int m, input int d,
                                                    input int h, input int mi);
    utca_pkg::utc_stamp_t s;
    s.year_in = 7'(y);
    s.month_in = 4'(m);
    s.day_in = 5'(d);
    s.hour_in = 5'(h);
    s.minute_in = 6'(mi);
    return s;
  endfunction

  // mostly legal stamps biased to month/year edges, some raw bit patterns
  function automatic utca_pkg::utc_stamp_t rand_stamp();
    logic [26:0] raw;
    int y;
    int m;
    int d;
    int h;
    int mi;
    int len;
    if ($urandom_range(0, 7) == 0) begin
      raw = 27'($urandom);
      return raw;
    end
    case ($urandom_range(0, 3))
      0: y = 0;
      1: y = 99;
      default: y = $urandom_range(0, 99);
    endcase
    m = $urandom_range(1, 12);
    len = month_days(m);
    case ($urandom_range(0, 4))
      0: d = 1;
      1: d = len;
      2: d = len - 1;
      default: d = $urandom_range(1, len);
    endcase
    case ($urandom_range(0, 3))
      0: h = 0;
      1: h = 23;
      default: h = $urandom_range(0, 23);
    endcase
    case ($urandom_range(0, 5))
      0: mi = 0;
      1: mi = 59;
      2: mi = 29;
      3: mi = 30;
      default: mi = $urandom_range(0, 59);
    endcase
    return mk_stamp(y, m, d, h, mi);
  endfunction

  // called and returns at a falling edge; leaves start high
  task automatic send_stamp(input utca_pkg::utc_stamp_t s);
    start <= 1'b1;
    utc <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    local_time_q.push_back(predict_local_time(s, offset_reg));
    stamps_sent++;
    @(negedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic set_utc_offset(input logic [7:0] val);
    start <= 1'b0;
    while (local_time_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    offset_reg = val;
    offsets_applied++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic test_passthrough_after_reset();
    logic [26:0] ones;
    ones = '1;
    pace(); send_stamp(mk_stamp(0, 1, 1, 0, 0));
    pace(); send_stamp(mk_stamp(99, 12, 31, 23, 59));
    pace(); send_stamp(ones);
  endtask

  task automatic test_calendar_edges();
    set_utc_offset(8'sd120);
    pace(); send_stamp(mk_stamp(99, 12, 31, 23, 59));
    pace(); send_stamp(mk_stamp(50, 2, 28, 12, 0));
    pace(); send_stamp(mk_stamp(10, 4, 30, 11, 59));
    pace(); send_stamp(mk_stamp(20, 13, 31, 12, 0));
    pace(); send_stamp(mk_stamp(110, 12, 31, 20, 0));
    pace(); send_stamp(mk_stamp(33, 7, 15, 31, 10));

    set_utc_offset(-8'sd115);
    pace(); send_stamp(mk_stamp(0, 1, 1, 0, 0));
    pace(); send_stamp(mk_stamp(30, 3, 1, 5, 15));
    pace(); send_stamp(mk_stamp(40, 5, 0, 1, 0));
    pace(); send_stamp(mk_stamp(40, 0, 1, 3, 0));
    pace(); send_stamp(mk_stamp(120, 1, 1, 0, 0));
    pace(); send_stamp(mk_stamp(60, 8, 10, 12, 63));

    set_utc_offset(8'sd5);
    pace(); send_stamp(mk_stamp(12, 6, 30, 23, 30));
    pace(); send_stamp(mk_stamp(12, 6, 30, 23, 29));

    set_utc_offset(-8'sd5);
    pace(); send_stamp(mk_stamp(0, 1, 1, 0, 15));

    // out-of-band register values: odd remainder and full 8-bit extremes
    set_utc_offset(8'h80);
    pace(); send_stamp(mk_stamp(5, 3, 1, 0, 0));
    set_utc_offset(8'h7f);
    pace(); send_stamp(mk_stamp(5, 2, 28, 12, 40));
  endtask

  task automatic test_random_offsets();
    int off;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: off = 120;
        1: off = -115;
        2: off = -128;
        3: off = 127;
        4: off = 0;
        default: begin
          if ($urandom_range(0, 3) == 0) off = $urandom_range(0, 255);
          else off = 5 * $urandom_range(0, 47) - 115;
        end
      endcase
      set_utc_offset(8'(off));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pace();
        send_stamp(rand_stamp());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (local_time_q.size() == 0) begin
        error_count++;
        if (mismatch_count < 10) $display("unexpected result %p", adj);
        mismatch_count++;
      end else begin
        want = local_time_q.pop_front();
        stamps_checked++;
        if (adj.year_out !== want.year_out || adj.month_out !== want.month_out ||
            adj.day_out !== want.day_out || adj.hour_out !== want.hour_out ||
            adj.minute_out !== want.minute_out) begin
          error_count++;
          if (mismatch_count < 10) begin
            $display("mismatch: expected %0d-%0d-%0d %0d:%0d got %0d-%0d-%0d %0d:%0d",
                     want.year_out, want.month_out, want.day_out, want.hour_out,
                     want.minute_out, adj.year_out, adj.month_out, adj.day_out,
                     adj.hour_out, adj.minute_out);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    utc <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    offset_reg = '0;
    stamps_sent = 0;
    stamps_checked = 0;
    offsets_applied = 0;
    error_count = 0;
    mismatch_count = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_passthrough_after_reset();
    test_calendar_edges();
    test_random_offsets();

    start <= 1'b0;
    while (local_time_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (local_time_q.size() != 0) error_count++;

    $display("%0d timestamps sent, %0d checked, %0d offset writes, %0d errors",
             stamps_sent, stamps_checked, offsets_applied, error_count);
    $display("covered pass-through, half-hour and whole-hour carry/borrow, year wrap,");
    $display("out-of-range fields and full-range offsets");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/utca_pkg.sv
hw/rtl/utc_offset_calendar_adjust_unit.sv
verif/tb_top.sv
